>>> rtl/core/led_pkg.sv
// Package for the line ending style detector: beat types, style and tail codes,
// stream state type and the per-ending update and saturation functions.
// No dependencies.
package led_pkg;

   localparam int LINE_COUNT_BITS = 32;
   localparam int CSR_ADDR_BITS   = 3;
   localparam int CSR_DATA_BITS   = 32;

   localparam logic [CSR_ADDR_BITS-1:0] CSR_FULL_SCAN_MODE_ADDR = 3'd0;

   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;

   localparam logic [31:0] OUT_COUNT_MAX = 32'hFFFF_FFFF;

   typedef enum logic [2:0] {
      STYLE_LF     = 3'd0,
      STYLE_CRLF   = 3'd1,
      STYLE_CR     = 3'd2,
      STYLE_HYBRID = 3'd3,
      STYLE_NONE   = 3'd4
   } eol_style_type;

   localparam logic [1:0] END_LF   = 2'd0;
   localparam logic [1:0] END_CRLF = 2'd1;
   localparam logic [1:0] END_CR   = 2'd2;

   localparam logic [1:0] TAIL_NONE = 2'd0;
   localparam logic [1:0] TAIL_CRLF = 2'd1;
   localparam logic [1:0] TAIL_CR   = 2'd2;
   localparam logic [1:0] TAIL_LF   = 2'd3;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
      logic       whole_file;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]  eol_style;
      logic [31:0] line_count;
      logic [1:0]  earlier_style;
      logic [1:0]  differing_style;
      logic [31:0] differing_line;
      logic [1:0]  tail_ending;
   } rsp_payload_type;

   typedef struct packed {
      logic [2:0]                 style;
      logic [LINE_COUNT_BITS-1:0] lines;
      logic                       cr_pending;
      logic                       frozen;
      logic [7:0]                 prev_byte;
      logic                       has_prev;
      logic [1:0]                 earlier;
      logic [1:0]                 differing;
      logic [31:0]                diff_line;
   } scan_state_type;

   localparam scan_state_type SCAN_IDLE = '{style: STYLE_NONE, default: '0};

   function automatic logic [31:0] sat_count(input logic [LINE_COUNT_BITS:0] v);
      logic [LINE_COUNT_BITS+32:0] w;
      w = (LINE_COUNT_BITS+33)'(v);
      if (w > (LINE_COUNT_BITS+33)'(OUT_COUNT_MAX)) begin
         return OUT_COUNT_MAX;
      end
      return w[31:0];
   endfunction

   function automatic scan_state_type full_ending(input scan_state_type s,
                                                  input logic [1:0] e);
      scan_state_type       r;
      logic [LINE_COUNT_BITS:0] inc;
      r   = s;
      inc = {1'b0, s.lines} + (LINE_COUNT_BITS+1)'(1);
      if (!s.frozen) begin
         if (s.style == STYLE_NONE) begin
            r.style = {1'b0, e};
            r.lines = LINE_COUNT_BITS'(1);
         end else if (s.style == {1'b0, e}) begin
            if (s.lines != '1) begin
               r.lines = inc[LINE_COUNT_BITS-1:0];
            end
         end else begin
            r.earlier   = s.style[1:0];
            r.differing = e;
            r.diff_line = sat_count(inc);
            r.style     = STYLE_HYBRID;
            r.frozen    = 1'b1;
         end
      end
      return r;
   endfunction

endpackage

>>> rtl/core/line_ending_style_detector.sv
// Line ending style detector: a byte goes to the input register, and the result
// beat of a last byte is registered from the scan logic. Throughput one byte per
// cycle while no result beat stalls, bounded by the input register and scan logic.
// Synchronous active-high reset clears the mode to lazy and the stream state.
// Depends on led_pkg and led_scan.
module line_ending_style_detector import led_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  req_payload_type          req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rsp_payload_type          rsp_payload,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   logic            mode_ff;
   logic            in_valid_ff;
   logic            in_valid_in;
   req_payload_type in_beat_ff;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   rsp_payload_type rsp_beat_ff;
   rsp_payload_type scan_result;
   logic            out_free;
   logic            s1_go;
   logic            req_take;
   logic            csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && (paddr == CSR_FULL_SCAN_MODE_ADDR);
   assign prdata    = (paddr == CSR_FULL_SCAN_MODE_ADDR) ?
                      {{(CSR_DATA_BITS-1){1'b0}}, mode_ff} : '0;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_go     = in_valid_ff && (!in_beat_ff.last_byte || out_free);
   assign req_ready = !in_valid_ff || s1_go;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (s1_go) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_go && in_beat_ff.last_byte) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   led_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .go        (s1_go),
      .beat      (in_beat_ff),
      .full_mode (mode_ff),
      .result    (scan_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 1'b0;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            mode_ff <= pwdata[0];
         end
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_beat_ff <= req_payload;
      end
      if (s1_go && in_beat_ff.last_byte) begin
         rsp_beat_ff <= scan_result;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_beat_ff;

endmodule

>>> rtl/core/led_scan.sv
// Stream state of the detector and the per-beat classification logic.
// Depends on led_pkg.
module led_scan import led_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            go,
   input  req_payload_type beat,
   input  logic            full_mode,
   output rsp_payload_type result
);

   scan_state_type state_ff;
   scan_state_type state_in;

   always_comb begin
      scan_state_type s;
      logic           is_cr;
      logic           is_lf;
      logic [1:0]     tail;
      s     = state_ff;
      is_cr = (beat.data_byte == CHAR_CR);
      is_lf = (beat.data_byte == CHAR_LF);
      tail  = TAIL_NONE;

      if (full_mode) begin
         if (s.cr_pending) begin
            s.cr_pending = 1'b0;
            if (is_lf) begin
               s = full_ending(s, END_CRLF);
            end else begin
               s = full_ending(s, END_CR);
            end
         end
         if (!(state_ff.cr_pending && is_lf)) begin
            if (is_cr) begin
               s.cr_pending = 1'b1;
            end else if (is_lf) begin
               s = full_ending(s, END_LF);
            end
         end
      end else if (!s.frozen) begin
         if (s.cr_pending) begin
            s.cr_pending = 1'b0;
            s.style      = is_lf ? STYLE_CRLF : STYLE_CR;
            s.frozen     = 1'b1;
         end else if (is_cr) begin
            s.cr_pending = 1'b1;
         end else if (is_lf && s.style == STYLE_NONE) begin
            s.style = STYLE_LF;
         end
      end

      // flush a lone CR at the end of the buffer
      if (beat.last_byte && s.cr_pending) begin
         s.cr_pending = 1'b0;
         if (full_mode) begin
            s = full_ending(s, END_CR);
         end else if (!s.frozen) begin
            s.style  = STYLE_CR;
            s.frozen = 1'b1;
         end
      end

      if (beat.whole_file) begin
         priority if (state_ff.has_prev && state_ff.prev_byte == CHAR_CR) begin
            tail = is_lf ? TAIL_CRLF : TAIL_NONE;
         end else if (is_cr) begin
            tail = TAIL_CR;
         end else if (is_lf) begin
            tail = TAIL_LF;
         end else begin
            tail = TAIL_NONE;
         end
      end

      result.eol_style   = s.style;
      result.line_count  = sat_count({1'b0, s.lines});
      result.tail_ending = tail;
      if (s.style == STYLE_HYBRID) begin
         result.earlier_style   = s.earlier;
         result.differing_style = s.differing;
         result.differing_line  = s.diff_line;
      end else begin
         result.earlier_style   = 2'd0;
         result.differing_style = 2'd0;
         result.differing_line  = 32'd0;
      end

      if (beat.last_byte) begin
         state_in = SCAN_IDLE;
      end else begin
         state_in           = s;
         state_in.prev_byte = beat.data_byte;
         state_in.has_prev  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SCAN_IDLE;
      end else if (go) begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/core/led_checker.sv
// Port-level checks on the detector result channel, bound to the top level.
// Depends on led_pkg and line_ending_style_detector.
module led_checker import led_pkg::*; (
   input logic            clock,
   input logic            reset,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_payload
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result beat dropped or changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat right after reset");

   a_style_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.eol_style <= STYLE_NONE)
      else $error("style code out of range");

   a_plain_record: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.eol_style != STYLE_HYBRID |->
         rsp_payload.differing_line == 32'd0 && rsp_payload.earlier_style == 2'd0 &&
         rsp_payload.differing_style == 2'd0)
      else $error("hybrid record on a non-hybrid verdict");

   a_hybrid_record: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.eol_style == STYLE_HYBRID |->
         rsp_payload.differing_line != 32'd0 &&
         rsp_payload.earlier_style != rsp_payload.differing_style)
      else $error("hybrid verdict with an inconsistent record");

endmodule

bind line_ending_style_detector led_checker u_led_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
